>>> src/wmd_pkg.sv
// Shared types, constants and helpers for the waveguide mesh drum.
package wmd_pkg;

    localparam int SIDE      = 8;
    localparam int IDX_W     = 3;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DEPTH     = SIDE * SIDE;
    localparam int SAMPLE_W  = 32;
    localparam int TENSION_W = 14;
    localparam int POWER_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int SQ_W      = 28;
    localparam int G_W       = 25;
    localparam int CW_W      = 30;
    localparam int FRAC_W    = 28;

    localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(SIDE - 2);
    localparam logic [IDX_W-1:0] IDX_EDGE  = IDX_W'(SIDE - 1);
    localparam logic [IDX_W-1:0] IDX_ZERO  = IDX_W'(0);
    localparam logic [IDX_W-1:0] LOSS_IDX  = IDX_W'(SIDE - SIDE / 4);
    localparam logic [IDX_W-1:0] PICK_ROW  = IDX_W'(SIDE / 4);
    localparam logic [IDX_W-1:0] PICK_COL  = IDX_W'(SIDE / 4 - 1);

    // divide by nine as multiply by ceil(2^31 / 9) and shift; exact for any
    // dividend below 2^28
    localparam int               GAIN_PROD_W = 2 * SQ_W;
    localparam int               RECIP_SHIFT = 31;
    localparam logic [SQ_W-1:0]  RECIP_NINE  = SQ_W'(238609295);

    localparam logic [TENSION_W-1:0] TENSION_RESET = TENSION_W'(7209);
    localparam logic [TENSION_W-1:0] TENSION_MIN   = TENSION_W'(7);
    localparam logic [IDX_W-1:0]     STRIKE_RESET  = IDX_W'(1);
    localparam logic [26:0]          LOSS_COEF     = 27'd53687091;
    localparam logic signed [63:0]   ROUND_HALF    = 64'sd134217728;
    localparam logic [CW_W-1:0]      CW_BASE       = CW_W'(1) << 29;

    localparam logic [CFG_IDX_W-1:0] CFG_TENSION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COL     = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum logic [4:0] {
        OP_IDLE, OP_SQ, OP_DIV, OP_EX_RD, OP_EX_WR,
        OP_J_RD, OP_J_MUL, OP_J_ADD, OP_J_WR,
        OP_B_RD1, OP_B_RD2, OP_B_W1, OP_B_W2, OP_B_W3,
        OP_F_RD, OP_F_MUL, OP_F_WR, OP_O_RD, OP_O_LD, OP_CLEAR
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQ, ST_DIV, ST_EX_RD, ST_EX_WR,
        ST_J_RD, ST_J_MUL, ST_J_ADD, ST_J_WR,
        ST_B_RD1, ST_B_RD2, ST_B_W1, ST_B_W2, ST_B_W3,
        ST_F_RD, ST_F_MUL, ST_F_WR, ST_O_RD, ST_O_LD, ST_CLEAR
    } state_t;

    typedef struct packed {
        op_t              op;
        logic             accept;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } cmd_t;

    typedef struct packed {
        logic strike;
        logic out_blocked;
    } status_t;

    // Saturate a sign-extended value to the sample width.
    function automatic sample_t sat(input logic signed [63:0] x);
        sample_t r;
        r = x[SAMPLE_W-1:0];
        if (x > 64'(sample_t'({1'b0, {(SAMPLE_W-1){1'b1}}})))
            r = {1'b0, {(SAMPLE_W-1){1'b1}}};
        else if (x < -64'sd1 - 64'(sample_t'({1'b0, {(SAMPLE_W-1){1'b1}}})))
            r = {1'b1, {(SAMPLE_W-1){1'b0}}};
        return r;
    endfunction

endpackage

>>> src/wmd_ram.sv
// Single-write, single-read sample store with registered read.
module wmd_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_reg <= mem[raddr];
        end
    end

    assign rdata = rd_reg;

endmodule

>>> src/wmd_ctrl.sv
// Sequencer that clears the stores after reset, then walks each frame through its steps.
module wmd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  wmd_pkg::status_t status,
    output wmd_pkg::cmd_t    cmd
);

    wmd_pkg::state_t state_reg, state_next;
    logic [wmd_pkg::IDX_W-1:0]     i_reg, i_next, j_reg, j_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wmd_pkg::ST_CLEAR;
            i_reg     <= wmd_pkg::IDX_ZERO;
            j_reg     <= wmd_pkg::IDX_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        case (state_reg)
            wmd_pkg::ST_CLEAR:
            begin
                // advance one junction a cycle over the whole mesh
                if (j_reg == wmd_pkg::IDX_EDGE)
                begin
                    j_next = wmd_pkg::IDX_ZERO;
                    if (i_reg == wmd_pkg::IDX_EDGE)
                    begin
                        state_next = wmd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            wmd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = wmd_pkg::ST_SQ;
                end
            end
            wmd_pkg::ST_SQ:     state_next = wmd_pkg::ST_DIV;
            wmd_pkg::ST_DIV:
            begin
                i_next     = wmd_pkg::IDX_FIRST;
                j_next     = wmd_pkg::IDX_FIRST;
                state_next = status.strike ? wmd_pkg::ST_EX_RD : wmd_pkg::ST_J_RD;
            end
            wmd_pkg::ST_EX_RD:  state_next = wmd_pkg::ST_EX_WR;
            wmd_pkg::ST_EX_WR:  state_next = wmd_pkg::ST_J_RD;
            wmd_pkg::ST_J_RD:   state_next = wmd_pkg::ST_J_MUL;
            wmd_pkg::ST_J_MUL:  state_next = wmd_pkg::ST_J_ADD;
            wmd_pkg::ST_J_ADD:  state_next = wmd_pkg::ST_J_WR;
            wmd_pkg::ST_J_WR:
            begin
                if (j_reg == wmd_pkg::IDX_LAST)
                begin
                    state_next = wmd_pkg::ST_B_RD1;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = wmd_pkg::ST_J_RD;
                end
            end
            wmd_pkg::ST_B_RD1:  state_next = wmd_pkg::ST_B_RD2;
            wmd_pkg::ST_B_RD2:  state_next = wmd_pkg::ST_B_W1;
            wmd_pkg::ST_B_W1:   state_next = wmd_pkg::ST_B_W2;
            wmd_pkg::ST_B_W2:   state_next = wmd_pkg::ST_B_W3;
            wmd_pkg::ST_B_W3:
            begin
                if (i_reg == wmd_pkg::IDX_LAST)
                begin
                    state_next = wmd_pkg::ST_F_RD;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    j_next     = wmd_pkg::IDX_FIRST;
                    state_next = wmd_pkg::ST_J_RD;
                end
            end
            wmd_pkg::ST_F_RD:   state_next = wmd_pkg::ST_F_MUL;
            wmd_pkg::ST_F_MUL:  state_next = wmd_pkg::ST_F_WR;
            wmd_pkg::ST_F_WR:   state_next = wmd_pkg::ST_O_RD;
            wmd_pkg::ST_O_RD:   state_next = wmd_pkg::ST_O_LD;
            wmd_pkg::ST_O_LD:
            begin
                if (!status.out_blocked)
                begin
                    state_next = wmd_pkg::ST_IDLE;
                end
            end
            default:            state_next = wmd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.row    = i_reg;
        cmd.col    = j_reg;
        cmd.accept = 1'b0;
        in_stall   = 1'b1;
        case (state_reg)
            wmd_pkg::ST_IDLE:
            begin
                cmd.op     = wmd_pkg::OP_IDLE;
                cmd.accept = in_valid;
                in_stall   = 1'b0;
            end
            wmd_pkg::ST_CLEAR:  cmd.op = wmd_pkg::OP_CLEAR;
            wmd_pkg::ST_SQ:     cmd.op = wmd_pkg::OP_SQ;
            wmd_pkg::ST_DIV:    cmd.op = wmd_pkg::OP_DIV;
            wmd_pkg::ST_EX_RD:  cmd.op = wmd_pkg::OP_EX_RD;
            wmd_pkg::ST_EX_WR:  cmd.op = wmd_pkg::OP_EX_WR;
            wmd_pkg::ST_J_RD:   cmd.op = wmd_pkg::OP_J_RD;
            wmd_pkg::ST_J_MUL:  cmd.op = wmd_pkg::OP_J_MUL;
            wmd_pkg::ST_J_ADD:  cmd.op = wmd_pkg::OP_J_ADD;
            wmd_pkg::ST_J_WR:   cmd.op = wmd_pkg::OP_J_WR;
            wmd_pkg::ST_B_RD1:  cmd.op = wmd_pkg::OP_B_RD1;
            wmd_pkg::ST_B_RD2:  cmd.op = wmd_pkg::OP_B_RD2;
            wmd_pkg::ST_B_W1:   cmd.op = wmd_pkg::OP_B_W1;
            wmd_pkg::ST_B_W2:   cmd.op = wmd_pkg::OP_B_W2;
            wmd_pkg::ST_B_W3:   cmd.op = wmd_pkg::OP_B_W3;
            wmd_pkg::ST_F_RD:   cmd.op = wmd_pkg::OP_F_RD;
            wmd_pkg::ST_F_MUL:  cmd.op = wmd_pkg::OP_F_MUL;
            wmd_pkg::ST_F_WR:   cmd.op = wmd_pkg::OP_F_WR;
            wmd_pkg::ST_O_RD:   cmd.op = wmd_pkg::OP_O_RD;
            wmd_pkg::ST_O_LD:   cmd.op = wmd_pkg::OP_O_LD;
            default:            cmd.op = wmd_pkg::OP_IDLE;
        endcase
    end

endmodule

>>> src/wmd_datapath.sv
// Mesh stores, junction arithmetic, gain multiply, loss filter and output register.
module wmd_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  wmd_pkg::cmd_t                   cmd,
    output wmd_pkg::status_t                status,
    input  logic                            trigger_high,
    input  logic [wmd_pkg::POWER_W-1:0]     power_level,
    input  logic                            cfg_write,
    input  logic [wmd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wmd_pkg::TENSION_W-1:0]   cfg_data,
    output logic [wmd_pkg::SAMPLE_W-1:0]    sample_out,
    output logic                            out_valid,
    input  logic                            out_stall
);

    localparam int AW = wmd_pkg::ADDR_W;
    localparam int SW = wmd_pkg::SAMPLE_W;

    // configuration
    logic [wmd_pkg::TENSION_W-1:0] tension_reg;
    logic [wmd_pkg::IDX_W-1:0]     strike_row_reg, strike_col_reg;

    // frame control
    logic                          trig_reg, prev_trig_reg;
    logic [wmd_pkg::POWER_W-1:0]   power_reg;
    logic                          out_valid_reg;
    wmd_pkg::sample_t              out_data_reg;

    // gain
    logic [wmd_pkg::SQ_W-1:0]      div_x_reg;
    logic [wmd_pkg::G_W-1:0]       g_reg;
    logic [wmd_pkg::CW_W-1:0]      cw;
    logic [wmd_pkg::TENSION_W-1:0] t_eff;

    // arithmetic
    logic signed [59:0]            prod_a_reg;
    logic signed [62:0]            prod_b_reg;
    logic signed [60:0]            prod_f_reg;
    wmd_pkg::sample_t              v_reg, prev_unf_reg;
    wmd_pkg::sample_t              tmp_s_reg, neg_s_reg, tmp_e_reg, neg_e_reg;
    wmd_pkg::sample_t              tmp_n_reg, neg_n_reg, tmp_w_reg, neg_w_reg;
    logic signed [33:0]            wave_sum;
    logic signed [63:0]            j_acc, f_acc;

    // store ports: v n s e w c sh eh
    logic          v_we, n_we, s_we, e_we, w_we, c_we, sh_we, eh_we;
    logic          v_re, n_re, s_re, e_re, w_re, c_re, sh_re, eh_re;
    logic [AW-1:0] v_wa, n_wa, s_wa, e_wa, w_wa, c_wa, sh_wa, eh_wa;
    logic [AW-1:0] v_ra, n_ra, s_ra, e_ra, w_ra, c_ra, sh_ra, eh_ra;
    logic [SW-1:0] v_wd, n_wd, s_wd, e_wd, w_wd, c_wd, sh_wd, eh_wd;
    logic [SW-1:0] v_rd, n_rd, s_rd, e_rd, w_rd, c_rd, sh_rd, eh_rd;

    logic [wmd_pkg::IDX_W-1:0] i, j;
    logic [AW-1:0]             a_here;
    logic                      out_load;

    assign i      = cmd.row;
    assign j      = cmd.col;
    assign a_here = {i, j};

    assign t_eff = (tension_reg == '0) ? wmd_pkg::TENSION_MIN : tension_reg;
    assign cw    = wmd_pkg::CW_BASE - {3'b000, g_reg, 2'b00};

    assign wave_sum = 34'(signed'(n_rd)) + 34'(signed'(s_rd))
                    + 34'(signed'(e_rd)) + 34'(signed'(w_rd));
    assign j_acc = 64'(prod_a_reg) + 64'(prod_b_reg) + wmd_pkg::ROUND_HALF;
    assign f_acc = 64'(prod_f_reg) + wmd_pkg::ROUND_HALF;

    assign out_load           = (cmd.op == wmd_pkg::OP_O_LD) && !status.out_blocked;
    assign status.out_blocked = out_valid_reg && out_stall;
    assign status.strike      = trig_reg && !prev_trig_reg;
    assign sample_out         = out_data_reg;
    assign out_valid          = out_valid_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tension_reg    <= wmd_pkg::TENSION_RESET;
            strike_row_reg <= wmd_pkg::STRIKE_RESET;
            strike_col_reg <= wmd_pkg::STRIKE_RESET;
            prev_trig_reg  <= 1'b0;
            trig_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_unf_reg   <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    wmd_pkg::CFG_TENSION: tension_reg    <= cfg_data;
                    wmd_pkg::CFG_ROW:     strike_row_reg <= cfg_data[wmd_pkg::IDX_W-1:0];
                    wmd_pkg::CFG_COL:     strike_col_reg <= cfg_data[wmd_pkg::IDX_W-1:0];
                    default:              ;
                endcase
            end
            if (cmd.accept)
            begin
                trig_reg <= trigger_high;
            end
            if (cmd.op == wmd_pkg::OP_F_MUL)
            begin
                prev_unf_reg <= v_rd;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                prev_trig_reg <= trig_reg;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            power_reg <= power_level;
        end
        if (out_load)
        begin
            out_data_reg <= v_rd;
        end
        case (cmd.op)
            wmd_pkg::OP_SQ:
            begin
                div_x_reg <= wmd_pkg::SQ_W'(t_eff * t_eff) + wmd_pkg::SQ_W'(4);
            end
            wmd_pkg::OP_DIV:
            begin
                g_reg <= wmd_pkg::G_W'((wmd_pkg::GAIN_PROD_W'(div_x_reg)
                                        * wmd_pkg::GAIN_PROD_W'(wmd_pkg::RECIP_NINE))
                                       >> wmd_pkg::RECIP_SHIFT);
            end
            wmd_pkg::OP_J_MUL:
            begin
                prod_a_reg <= wave_sum * $signed({1'b0, g_reg});
                prod_b_reg <= $signed(c_rd) * $signed({1'b0, cw});
            end
            wmd_pkg::OP_J_ADD:
            begin
                v_reg <= wmd_pkg::sat(j_acc >>> wmd_pkg::FRAC_W);
            end
            wmd_pkg::OP_B_RD2:
            begin
                tmp_s_reg <= s_rd;
                neg_s_reg <= wmd_pkg::sat(-64'(signed'(n_rd)));
                tmp_e_reg <= e_rd;
                neg_e_reg <= wmd_pkg::sat(-64'(signed'(w_rd)));
            end
            wmd_pkg::OP_B_W1:
            begin
                tmp_n_reg <= n_rd;
                neg_n_reg <= wmd_pkg::sat(-64'(signed'(s_rd)));
                tmp_w_reg <= w_rd;
                neg_w_reg <= wmd_pkg::sat(-64'(signed'(e_rd)));
            end
            wmd_pkg::OP_F_MUL:
            begin
                prod_f_reg <= (33'(signed'(v_rd)) + 33'(prev_unf_reg))
                            * $signed({1'b0, wmd_pkg::LOSS_COEF});
            end
            default: ;
        endcase
    end

    // store port steering
    always_comb
    begin
        {v_we, n_we, s_we, e_we, w_we, c_we, sh_we, eh_we} = '0;
        {v_re, n_re, s_re, e_re, w_re, c_re, sh_re, eh_re} = '0;
        {v_wa, n_wa, s_wa, e_wa, w_wa, c_wa, sh_wa, eh_wa} = '0;
        {v_ra, n_ra, s_ra, e_ra, w_ra, c_ra, sh_ra, eh_ra} = '0;
        {v_wd, n_wd, s_wd, e_wd, w_wd, c_wd, sh_wd, eh_wd} = '0;
        case (cmd.op)
            wmd_pkg::OP_CLEAR:
            begin
                // zero one junction in every store
                {v_we, n_we, s_we, e_we, w_we, c_we, sh_we, eh_we} = '1;
                v_wa  = a_here;
                n_wa  = a_here;
                s_wa  = a_here;
                e_wa  = a_here;
                w_wa  = a_here;
                c_wa  = a_here;
                sh_wa = a_here;
                eh_wa = a_here;
            end
            wmd_pkg::OP_EX_RD:
            begin
                {v_re, n_re, s_re, e_re, w_re} = '1;
                v_ra = {strike_row_reg, strike_col_reg};
                n_ra = v_ra;
                s_ra = v_ra;
                e_ra = v_ra;
                w_ra = v_ra;
            end
            wmd_pkg::OP_EX_WR:
            begin
                {v_we, n_we, s_we, e_we, w_we} = '1;
                v_wa = {strike_row_reg, strike_col_reg};
                n_wa = v_wa;
                s_wa = v_wa;
                e_wa = v_wa;
                w_wa = v_wa;
                v_wd = wmd_pkg::sat(64'(signed'(v_rd)) + 64'({power_reg, 6'b0}));
                n_wd = wmd_pkg::sat(64'(signed'(n_rd)) + 64'(power_reg * 10'd900));
                s_wd = wmd_pkg::sat(64'(signed'(s_rd)) + 64'(power_reg * 10'd900));
                e_wd = wmd_pkg::sat(64'(signed'(e_rd)) + 64'(power_reg * 10'd900));
                w_wd = wmd_pkg::sat(64'(signed'(w_rd)) + 64'(power_reg * 10'd900));
            end
            wmd_pkg::OP_J_RD:
            begin
                {n_re, s_re, e_re, w_re, c_re, sh_re, eh_re} = '1;
                n_ra  = a_here;
                s_ra  = a_here;
                e_ra  = a_here;
                w_ra  = a_here;
                c_ra  = a_here;
                sh_ra = a_here;
                eh_ra = a_here;
            end
            wmd_pkg::OP_J_WR:
            begin
                {v_we, n_we, s_we, e_we, w_we, c_we, sh_we, eh_we} = '1;
                v_wa  = a_here;
                v_wd  = v_reg;
                s_wa  = {i, j + 1'b1};
                s_wd  = wmd_pkg::sat(64'(v_reg) - 64'(signed'(n_rd)));
                n_wa  = {i, j - 1'b1};
                n_wd  = wmd_pkg::sat(64'(v_reg) - 64'(signed'(sh_rd)));
                e_wa  = {i + 1'b1, j};
                e_wd  = wmd_pkg::sat(64'(v_reg) - 64'(signed'(w_rd)));
                w_wa  = {i - 1'b1, j};
                w_wd  = wmd_pkg::sat(64'(v_reg) - 64'(signed'(eh_rd)));
                c_wa  = a_here;
                c_wd  = wmd_pkg::sat(64'(v_reg) - 64'(signed'(c_rd)));
                sh_wa = a_here;
                sh_wd = s_rd;
                eh_wa = a_here;
                eh_wd = e_rd;
            end
            wmd_pkg::OP_B_RD1:
            begin
                {n_re, s_re, e_re, w_re} = '1;
                s_ra = {i, wmd_pkg::IDX_ZERO};
                n_ra = s_ra;
                e_ra = {wmd_pkg::IDX_ZERO, i};
                w_ra = e_ra;
            end
            wmd_pkg::OP_B_RD2:
            begin
                {n_re, s_re, e_re, w_re} = '1;
                s_ra = {i, wmd_pkg::IDX_EDGE};
                n_ra = s_ra;
                e_ra = {wmd_pkg::IDX_EDGE, i};
                w_ra = e_ra;
            end
            wmd_pkg::OP_B_W1:
            begin
                {s_we, e_we, sh_we, eh_we} = '1;
                s_wa  = {i, wmd_pkg::IDX_ZERO};
                s_wd  = neg_s_reg;
                e_wa  = {wmd_pkg::IDX_ZERO, i};
                e_wd  = neg_e_reg;
                sh_wa = {i, wmd_pkg::IDX_FIRST};
                sh_wd = tmp_s_reg;
                eh_wa = {wmd_pkg::IDX_FIRST, i};
                eh_wd = tmp_e_reg;
            end
            wmd_pkg::OP_B_W2:
            begin
                {s_we, e_we, n_we, w_we} = '1;
                s_wa = {i, wmd_pkg::IDX_FIRST};
                s_wd = tmp_s_reg;
                e_wa = {wmd_pkg::IDX_FIRST, i};
                e_wd = tmp_e_reg;
                n_wa = {i, wmd_pkg::IDX_EDGE};
                n_wd = neg_n_reg;
                w_wa = {wmd_pkg::IDX_EDGE, i};
                w_wd = neg_w_reg;
            end
            wmd_pkg::OP_B_W3:
            begin
                {n_we, w_we} = '1;
                n_wa = {i, wmd_pkg::IDX_LAST};
                n_wd = tmp_n_reg;
                w_wa = {wmd_pkg::IDX_LAST, i};
                w_wd = tmp_w_reg;
            end
            wmd_pkg::OP_F_RD:
            begin
                v_re = 1'b1;
                v_ra = {wmd_pkg::LOSS_IDX, wmd_pkg::LOSS_IDX};
            end
            wmd_pkg::OP_F_WR:
            begin
                v_we = 1'b1;
                v_wa = {wmd_pkg::LOSS_IDX, wmd_pkg::LOSS_IDX};
                v_wd = wmd_pkg::sat(f_acc >>> wmd_pkg::FRAC_W);
            end
            wmd_pkg::OP_O_RD:
            begin
                v_re = 1'b1;
                v_ra = {wmd_pkg::PICK_ROW, wmd_pkg::PICK_COL};
            end
            default: ;
        endcase
    end

    wmd_ram #(.DEPTH(wmd_pkg::DEPTH), .WIDTH(SW)) u_v (
        .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd),
        .re(v_re), .raddr(v_ra), .rdata(v_rd));
    wmd_ram #(.DEPTH(wmd_pkg::DEPTH), .WIDTH(SW)) u_n (
        .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd),
        .re(n_re), .raddr(n_ra), .rdata(n_rd));
    wmd_ram #(.DEPTH(wmd_pkg::DEPTH), .WIDTH(SW)) u_s (
        .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd),
        .re(s_re), .raddr(s_ra), .rdata(s_rd));
    wmd_ram #(.DEPTH(wmd_pkg::DEPTH), .WIDTH(SW)) u_e (
        .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd),
        .re(e_re), .raddr(e_ra), .rdata(e_rd));
    wmd_ram #(.DEPTH(wmd_pkg::DEPTH), .WIDTH(SW)) u_w (
        .clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd),
        .re(w_re), .raddr(w_ra), .rdata(w_rd));
    wmd_ram #(.DEPTH(wmd_pkg::DEPTH), .WIDTH(SW)) u_c (
        .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd),
        .re(c_re), .raddr(c_ra), .rdata(c_rd));
    wmd_ram #(.DEPTH(wmd_pkg::DEPTH), .WIDTH(SW)) u_sh (
        .clk(clk), .we(sh_we), .waddr(sh_wa), .wdata(sh_wd),
        .re(sh_re), .raddr(sh_ra), .rdata(sh_rd));
    wmd_ram #(.DEPTH(wmd_pkg::DEPTH), .WIDTH(SW)) u_eh (
        .clk(clk), .we(eh_we), .waddr(eh_wa), .wdata(eh_wd),
        .re(eh_re), .raddr(eh_ra), .rdata(eh_rd));

endmodule

>>> src/waveguide_mesh_drum.sv
// Top level of the waveguide mesh drum: sequencer plus datapath.
//
// Usage: each input item (trigger_high, power_level) is one audio frame and
// yields exactly one output item, sample_out, the velocity at the pickup
// junction in signed Q12.20. An item is taken when in_valid is high and
// in_stall is low; a result leaves when out_valid is high and out_stall low.
// The block works on one frame at a time: an item is taken only in the idle
// state, and the next item can be taken as soon as the previous result has
// been loaded into the output register. Each frame forms the scattering gain
// from the tension square and a reciprocal multiply, adds an excitation read
// and write on a strike, scans the 36 inner junctions (read, multiply in
// the shared multipliers, add, write back), runs the six boundary passes,
// bound by the one read port per store, and ends with the loss filter and
// output load.
// Reset loads the default tension and strike point, then a clearing pass
// zeroes every mesh store entry, one junction a cycle; in_stall stays high
// until it ends.
// When the receiver stalls, the finished result holds in the output register;
// the next frame is computed meanwhile and waits at its last step until the
// register frees. Write configuration only while the block is idle.
module waveguide_mesh_drum (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            trigger_high,
    input  logic [wmd_pkg::POWER_W-1:0]     power_level,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [wmd_pkg::SAMPLE_W-1:0] sample_out,
    input  logic                            cfg_write,
    input  logic [wmd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wmd_pkg::TENSION_W-1:0]   cfg_data
);

    wmd_pkg::cmd_t    cmd;
    wmd_pkg::status_t status;

    // sequencer: clears the stores, then steps through one frame per accepted item
    wmd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // stores, arithmetic and output register
    wmd_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .trigger_high (trigger_high),
        .power_level  (power_level),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_out   (sample_out),
        .out_valid    (out_valid),
        .out_stall    (out_stall)
    );

endmodule
